// ===== rtl/orbf_pkg.sv =====
// Shared types and constants for the overwrite ring log buffer.
`timescale 1ns / 1ps

package orbf_pkg;

  // Default ring depth; the ring holds at most depth minus one bytes.
  localparam int DEFAULT_DEPTH = 64;

  // Percent figures used by the drain triggers.
  localparam int ALMOST_FULL_PERCENT = 90;
  localparam int PERCENT_SCALE       = 100;

  // Request kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FLUSH_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD_PCT  = 2'd1;
  localparam logic [1:0] CFG_MAX_BYTES      = 2'd2;

  // Configuration register file.
  typedef struct packed {
    logic [31:0] flush_interval;
    logic [6:0]  threshold_percent;
    logic [6:0]  max_bytes_per_flush;
  } cfg_t;

  // Flush request context handed to the trigger logic.
  typedef struct packed {
    logic        force_drain;
    logic        overflow_pending;
    logic [31:0] now_time;
    logic [31:0] last_flush_time;
  } flush_ctx_t;

endpackage

// ===== rtl/orbf_ram.sv =====
// Byte ring storage: one write port and one registered read port.
`timescale 1ns / 1ps

module orbf_ram
  import orbf_pkg::*;
#(
  parameter int BufferDepth = DEFAULT_DEPTH,
  parameter int IdxW        = $clog2(BufferDepth)
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [7:0]      wr_data_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [7:0]      rd_data_o
);

  logic [7:0] mem [BufferDepth];
  logic [7:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/orbf_trig.sv =====
// Drain decision and drain length for a flush request.
`timescale 1ns / 1ps

module orbf_trig
  import orbf_pkg::*;
#(
  parameter int BufferDepth = DEFAULT_DEPTH,
  parameter int IdxW        = $clog2(BufferDepth)
) (
  input  cfg_t            cfg_i,
  input  flush_ctx_t      ctx_i,
  input  logic [IdxW-1:0] count_i,
  output logic            drain_o,
  output logic [IdxW-1:0] drain_len_o
);

  // Product width: covers 100 * count and depth * percent.
  localparam int PW = IdxW + 8;
  localparam logic [IdxW:0] AlmostFull =
    (IdxW+1)'(BufferDepth * ALMOST_FULL_PERCENT / PERCENT_SCALE);

  logic [PW-1:0] depth_pct;
  logic [PW-1:0] count_pct;
  logic [31:0]   elapsed;
  logic          almost_full_hit;
  logic          thresh_hit;
  logic          interval_hit;
  logic          capped;

  // The fill exceeds depth*p/100 (rounded down) exactly when 100*fill > depth*p.
  assign depth_pct = PW'(BufferDepth) * PW'(cfg_i.threshold_percent);
  assign count_pct = PW'(count_i) * PW'(PERCENT_SCALE);
  assign thresh_hit = (depth_pct >= PW'(PERCENT_SCALE)) && (count_pct > depth_pct);

  assign almost_full_hit = {1'b0, count_i} > AlmostFull;

  // Modular time since the last drain.
  assign elapsed      = ctx_i.now_time - ctx_i.last_flush_time;
  assign interval_hit = (cfg_i.flush_interval != 32'd0) && (elapsed > cfg_i.flush_interval);

  assign drain_o = (ctx_i.force_drain || almost_full_hit || thresh_hit ||
                    interval_hit || ctx_i.overflow_pending) && (count_i != '0);

  // Cap the drain length; a cap below the fill is always below the depth.
  assign capped = (cfg_i.max_bytes_per_flush != 7'd0) &&
                  (8'(count_i) > 8'(cfg_i.max_bytes_per_flush));
  assign drain_len_o = capped ? IdxW'(cfg_i.max_bytes_per_flush) : count_i;

endmodule

// ===== rtl/overwrite_ring_buffer_with_flush.sv =====
// Top level of the overwrite ring log buffer with conditional flush.
`timescale 1ns / 1ps

// Byte log buffer. Requests arrive on the in channel (valid/ready). A write
// request either sends its byte straight to the out channel or stores it in a
// ring memory; a full ring drops its oldest byte and marks an overflow. A
// flush request checks the drain triggers and, if one fires, sends the stored
// bytes oldest first, capped by max_bytes_per_flush. Registers are written on
// the cfg channel, which is always ready; write them only while idle.
// Timing: a direct byte is valid in the cycle after its request is taken. A
// flush is first evaluated, then its first byte is read from the ring memory
// and moved into the output register; further bytes follow one per cycle while
// the receiver is ready, paced by the single read port of the ring memory.
// A buffered write does not hold the in channel. A flush that does not drain
// holds it while it is evaluated; one that drains holds it until its last byte
// is in the output register. The in channel is ready only while no flush is
// being evaluated or drained and the output register is free or being emptied.
// Reset empties the ring and clears the overflow mark, the last flush time and
// the configuration registers. When the receiver stalls, the output register
// holds its byte and the drain waits with the next byte already read.
module overwrite_ring_buffer_with_flush
  import orbf_pkg::*;
#(
  parameter int BufferDepth = DEFAULT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        buffered_i,
  input  logic        flush_now_i,
  input  logic [31:0] now_time_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        overflow_seen_o,
  output logic        last_o,
  // Configuration channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int IdxW = $clog2(BufferDepth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(BufferDepth - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] wr_q, wr_d, rd_q, rd_d, count_q, count_d, rem_q, rem_d;
  logic [IdxW-1:0] wr_nx, rd_nx;
  logic            ovf_q, ovf_d, first_q, first_d, force_q, force_d;
  logic [31:0]     last_flush_q, last_flush_d, now_q, now_d;
  logic            out_valid_q, out_valid_d, out_ovf_q, out_ovf_d, out_last_q, out_last_d;
  logic [7:0]      out_byte_q, out_byte_d;
  cfg_t            cfg_q;

  logic            slot_free, in_acc;
  logic            ram_we, ram_re;
  logic [7:0]      ram_rdata;
  logic            drain;
  logic [IdxW-1:0] drain_len;
  flush_ctx_t      ctx;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FLUSH_INTERVAL: cfg_q.flush_interval      <= cfg_data_i;
        CFG_THRESHOLD_PCT:  cfg_q.threshold_percent   <= cfg_data_i[6:0];
        CFG_MAX_BYTES:      cfg_q.max_bytes_per_flush <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Ring memory.
  orbf_ram #(
    .BufferDepth(BufferDepth),
    .IdxW       (IdxW)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ram_we),
    .wr_addr_i(wr_q),
    .wr_data_i(data_byte_i),
    .rd_en_i  (ram_re),
    .rd_addr_i(rd_q),
    .rd_data_o(ram_rdata)
  );

  // Drain trigger evaluation on the captured flush request.
  assign ctx.force_drain      = force_q;
  assign ctx.overflow_pending = ovf_q;
  assign ctx.now_time         = now_q;
  assign ctx.last_flush_time  = last_flush_q;

  orbf_trig #(
    .BufferDepth(BufferDepth),
    .IdxW       (IdxW)
  ) u_trig (
    .cfg_i      (cfg_q),
    .ctx_i      (ctx),
    .count_i    (count_q),
    .drain_o    (drain),
    .drain_len_o(drain_len)
  );

  // Ring index increments.
  assign wr_nx = (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
  assign rd_nx = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // Sequencer: request decode, flush evaluation and drain.
  always_comb begin
    state_d      = state_q;
    wr_d         = wr_q;
    rd_d         = rd_q;
    count_d      = count_q;
    rem_d        = rem_q;
    ovf_d        = ovf_q;
    first_d      = first_q;
    force_d      = force_q;
    now_d        = now_q;
    last_flush_d = last_flush_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    out_ovf_d    = out_ovf_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_FLUSH) begin
            force_d = flush_now_i;
            now_d   = now_time_i;
            state_d = ST_EVAL;
          end else if (!buffered_i) begin
            out_valid_d = 1'b1;
            out_byte_d  = data_byte_i;
            out_ovf_d   = 1'b0;
            out_last_d  = 1'b1;
          end else begin
            // Store; a full ring drops its oldest byte.
            ram_we = 1'b1;
            wr_d   = wr_nx;
            if (wr_nx == rd_q) begin
              rd_d  = rd_nx;
              ovf_d = 1'b1;
            end else begin
              count_d = count_q + 1'b1;
            end
          end
        end
      end
      ST_EVAL: begin
        if (drain) begin
          ram_re       = 1'b1;
          rd_d         = rd_nx;
          count_d      = count_q - 1'b1;
          rem_d        = drain_len;
          first_d      = ovf_q;
          ovf_d        = 1'b0;
          last_flush_d = now_q;
          state_d      = ST_DRAIN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        // Read data is always ready here; move it out and read ahead.
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = ram_rdata;
          out_ovf_d   = first_q;
          out_last_d  = (rem_q == IdxW'(1));
          first_d     = 1'b0;
          rem_d       = rem_q - 1'b1;
          if (rem_q == IdxW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            ram_re  = 1'b1;
            rd_d    = rd_nx;
            count_d = count_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wr_q         <= '0;
      rd_q         <= '0;
      count_q      <= '0;
      rem_q        <= '0;
      ovf_q        <= 1'b0;
      first_q      <= 1'b0;
      last_flush_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      wr_q         <= wr_d;
      rd_q         <= rd_d;
      count_q      <= count_d;
      rem_q        <= rem_d;
      ovf_q        <= ovf_d;
      first_q      <= first_d;
      last_flush_q <= last_flush_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    force_q    <= force_d;
    now_q      <= now_d;
    out_byte_q <= out_byte_d;
    out_ovf_q  <= out_ovf_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign overflow_seen_o = out_ovf_q;
  assign last_o          = out_last_q;

`ifndef SYNTH
  // The fill count always matches the distance between the ring indexes.
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == ((wr_q >= rd_q) ? (wr_q - rd_q) : (IdxW'(BufferDepth) - (rd_q - wr_q))))
    else $error("fill count out of step with ring indexes");

  // A drain in progress always has bytes left to send.
  a_drain_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (rem_q != '0))
    else $error("drain running with no bytes left");

  // A byte taken that is not the last of its run is followed at once by the next one.
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> out_valid_o)
    else $error("drain ended before its last byte");

  // The overflow mark is cleared as soon as a drain starts.
  a_ovf_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && drain) |=> !ovf_q)
    else $error("overflow mark survived a drain");
`endif

endmodule
